>>> sv/pfrt_pkg.sv
// Shared types and codes for the port-forward rule table.
`default_nettype none

package pfrt_pkg;

  localparam int unsigned TYPE_W = 2;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned SLOT_W = 4;

  localparam logic [TYPE_W-1:0] TYPE_NONE = 2'd0;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUP_EMU   = 3'd1,
    ST_DUP_HOST  = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    op_e               op;
    logic [TYPE_W-1:0] rule_type;
    logic [PORT_W-1:0] guest_port;
    logic [PORT_W-1:0] ext_port;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  typedef struct packed {
    logic [TYPE_W-1:0] rule_type;
    logic [PORT_W-1:0] guest_port;
    logic [PORT_W-1:0] ext_port;
  } entry_t;

  typedef struct packed {
    logic emu_hit;
    logic host_hit;
    logic full_hit;
    logic free;
  } match_t;

endpackage

`default_nettype wire

>>> sv/pfrt_store.sv
// Rule storage: entry memory with per-entry occupied bits and a registered read port.
`default_nettype none

module pfrt_store import pfrt_pkg::*; #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [IW-1:0] rd_addr_i,
  output entry_t             rd_entry_o,
  output logic               rd_vld_o,
  input  wire logic          wr_en_i,
  input  wire logic          clr_en_i,
  input  wire logic [IW-1:0] wr_addr_i,
  input  entry_t             wr_entry_i
);

  logic [ENTRIES-1:0] valid_q;
  entry_t             mem_q [ENTRIES];
  entry_t             rd_entry_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_vld_o   = rd_vld_q;

endmodule

`default_nettype wire

>>> sv/pfrt_cmp.sv
// Shared compare unit: tests one stored entry against the pending request.
`default_nettype none

module pfrt_cmp import pfrt_pkg::*; (
  input  entry_t     req_i,
  input  entry_t     ent_i,
  input  wire logic  vld_i,
  output match_t     match_o
);

  logic type_eq;
  logic emu_eq;
  logic host_eq;

  assign type_eq = vld_i && (ent_i.rule_type == req_i.rule_type);
  assign emu_eq  = (ent_i.guest_port == req_i.guest_port);
  assign host_eq = (ent_i.ext_port == req_i.ext_port);

  assign match_o.emu_hit  = type_eq && emu_eq;
  assign match_o.host_hit = type_eq && host_eq;
  assign match_o.full_hit = type_eq && emu_eq && host_eq;
  assign match_o.free     = !vld_i;

endmodule

`default_nettype wire

>>> sv/port_forward_rule_table.sv
// Port-forward rule table: request sequencer and scan control, top level.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) carries one request word:
// add or remove a rule of a given protocol type with an emulated-side and a
// host-side port. Output channel (out_valid_o / out_stall_i / out_word_o)
// returns exactly one status word per request, with the slot written or cleared.
// Each request scans the table one entry per cycle through a single compare
// unit fed from the entry memory's registered read port. A request with a
// protocol type of zero skips the scan. A duplicate hit or a removal hit ends
// the scan early. The next request is taken the cycle after the result is
// loaded into the output register. in_stall_o is high while a request is in
// progress. If the receiver stalls, the result waits in the output register;
// the next request is accepted meanwhile, and its result waits for that
// register. Reset empties the table at once (per-entry occupied bits) and
// drops any request or result in progress.
`default_nettype none

module port_forward_rule_table import pfrt_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  fsm_e      state_q, state_d;
  in_word_t  req_q;
  logic [IW-1:0] cnt_q;
  logic          iss_q;
  logic          live_q;
  logic [IW-1:0] idx_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;
  out_word_t res_q, res_d;
  logic      out_valid_q;
  out_word_t out_word_q;

  logic          accept;
  logic          done;
  logic          out_load;
  logic          rd_en;
  logic          wr_en;
  logic          clr_en;
  logic [IW-1:0] wr_addr;
  logic          last_rd;
  entry_t        req_entry;
  entry_t        rd_entry;
  logic          rd_vld;
  match_t        match;

  assign req_entry.rule_type  = req_q.rule_type;
  assign req_entry.guest_port = req_q.guest_port;
  assign req_entry.ext_port   = req_q.ext_port;

  pfrt_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q),
    .rd_entry_o(rd_entry),
    .rd_vld_o  (rd_vld),
    .wr_en_i   (wr_en),
    .clr_en_i  (clr_en),
    .wr_addr_i (wr_addr),
    .wr_entry_i(req_entry)
  );

  pfrt_cmp u_cmp (
    .req_i  (req_entry),
    .ent_i  (rd_entry),
    .vld_i  (rd_vld),
    .match_o(match)
  );

  assign in_stall_o = (state_q != FSM_IDLE);
  assign accept     = in_valid_i && (state_q == FSM_IDLE);
  assign out_load   = (state_q == FSM_OUT) && (!out_valid_q || !out_stall_i);
  assign last_rd    = (idx_q == LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = (in_word_i.rule_type == TYPE_NONE) ? FSM_OUT : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (done) begin
          state_d = FSM_OUT;
        end
      end
      FSM_OUT: begin
        if (out_load) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // scan decisions and table writes
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    clr_en  = 1'b0;
    wr_addr = idx_q;
    done    = 1'b0;
    res_d   = res_q;
    case (state_q)
      FSM_SCAN: begin
        rd_en = iss_q;
        if (live_q) begin
          if (req_q.op == OP_REMOVE) begin
            if (match.full_hit) begin
              done   = 1'b1;
              clr_en = 1'b1;
              res_d  = '{status: ST_REMOVED, slot: SLOT_W'(idx_q)};
            end else if (last_rd) begin
              done  = 1'b1;
              res_d = '{status: ST_NOT_FOUND, slot: '0};
            end
          end else begin
            if (match.emu_hit) begin
              done  = 1'b1;
              res_d = '{status: ST_DUP_EMU, slot: '0};
            end else if (match.host_hit) begin
              done  = 1'b1;
              res_d = '{status: ST_DUP_HOST, slot: '0};
            end else if (last_rd) begin
              done = 1'b1;
              if (free_found_q) begin
                wr_en   = 1'b1;
                wr_addr = free_idx_q;
                res_d   = '{status: ST_ADDED, slot: SLOT_W'(free_idx_q)};
              end else if (match.free) begin
                wr_en   = 1'b1;
                wr_addr = idx_q;
                res_d   = '{status: ST_ADDED, slot: SLOT_W'(idx_q)};
              end else begin
                res_d = '{status: ST_FULL, slot: '0};
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      cnt_q        <= '0;
      iss_q        <= 1'b0;
      live_q       <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q        <= '0;
        iss_q        <= 1'b1;
        live_q       <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == FSM_SCAN) begin
        if (done) begin
          iss_q  <= 1'b0;
          live_q <= 1'b0;
        end else begin
          live_q <= iss_q;
          if (iss_q) begin
            if (cnt_q == LAST) begin
              iss_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (live_q && match.free && !free_found_q) begin
            free_found_q <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_word_i;
      res_q <= '{status: (in_word_i.op == OP_REMOVE) ? ST_NOT_FOUND : ST_FULL, slot: '0};
    end else if (done) begin
      res_q <= res_d;
    end
    if (state_q == FSM_SCAN && iss_q) begin
      idx_q <= cnt_q;
    end
    if (state_q == FSM_SCAN && live_q && match.free && !free_found_q) begin
      free_idx_q <= idx_q;
    end
    if (out_load) begin
      out_word_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != FSM_IDLE))
    else $error("request accepted but sequencer idle");

  a_load_only_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result load did not raise valid");

  a_single_table_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && clr_en))
    else $error("add and remove in the same cycle");

  a_table_op_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en || clr_en) |-> (done && state_q == FSM_SCAN))
    else $error("table changed outside a finished scan");

  a_read_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> (state_q == FSM_SCAN))
    else $error("read data live outside scan");

endmodule

`default_nettype wire
